>>> design/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder and its channels.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned UnitCountW = 20;
  localparam int unsigned CodeUnitW  = 16;
  localparam int unsigned AccW       = 21;

  // byte classes
  localparam logic [7:0] AsciiLimit  = 8'h80;
  localparam logic [7:0] Lead2Min    = 8'hC2;
  localparam logic [7:0] Lead3Min    = 8'hE0;
  localparam logic [7:0] Lead4Min    = 8'hF0;
  localparam logic [7:0] LeadLimit   = 8'hF8;
  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContTag     = 8'h80;

  // code point limits
  localparam logic [AccW-1:0] CpMax     = 21'h10FFFF;
  localparam logic [AccW-1:0] SurrMin   = 21'h00D800;
  localparam logic [AccW-1:0] SurrMax   = 21'h00DFFF;
  localparam logic [AccW-1:0] SuppBase  = 21'h010000;
  localparam logic [CodeUnitW-1:0] HiSurrBase = 16'hD800;
  localparam logic [CodeUnitW-1:0] LoSurrBase = 16'hDC00;

  // phase values: continuation bytes still expected
  localparam logic [1:0] PhaseLead = 2'd0;
  localparam logic [1:0] PhaseOne  = 2'd1;
  localparam logic [1:0] PhaseTwo  = 2'd2;
  localparam logic [1:0] PhaseThree = 2'd3;

  typedef enum logic [1:0] {
    KIND_UNIT  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } item_kind_e;

  typedef struct packed {
    item_kind_e             item_kind;
    logic [CodeUnitW-1:0]   code_unit;
    logic [UnitCountW-1:0]  unit_count;
    logic                   last_of_string;
  } result_t;

endpackage

>>> design/u8u16_if.sv
// ----------------------------------------------------------------------------
// u8u16 channels
// Valid/ready channels for input bytes, result items and the mode register.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_string;

  modport source (output valid, output byte_in, output end_of_string, input ready);
  modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

interface u8u16_out_if;
  logic                                valid;
  logic                                ready;
  u8u16_pkg::item_kind_e               item_kind;
  logic [u8u16_pkg::CodeUnitW-1:0]     code_unit;
  logic [u8u16_pkg::UnitCountW-1:0]    unit_count;
  logic                                last_of_string;

  modport source (output valid, output item_kind, output code_unit, output unit_count,
                  output last_of_string, input ready);
  modport sink   (input valid, input item_kind, input code_unit, input unit_count,
                  input last_of_string, output ready);
endinterface

interface u8u16_cfg_if;
  logic valid;
  logic ready;
  logic emit_units;

  modport source (output valid, output emit_units, input ready);
  modport sink   (input valid, input emit_units, output ready);
endinterface

>>> design/utf8_to_utf16_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Decodes a UTF-8 byte stream into UTF-16 code units and string status items.
// ----------------------------------------------------------------------------
// in_i takes one UTF-8 byte per transaction, with end_of_string on the last
// byte of a bounded string. out_o gives code units (kind 0) and one status
// item per string (kind 1 finished, kind 2 error) with the running unit count.
// cfg_i writes emit_units; with it cleared only status items come out.
// An accepted byte lands in an input register; the next cycle decodes it and
// writes its zero to three result items into a four-entry result queue, whose
// head drives out_o. One byte is taken every cycle as long as each byte
// yields at most one item; a byte that ends a surrogate pair or closes a
// string adds one or two items, and the decode stage waits until the queue
// has room for them, so the output channel at one item per cycle sets the
// overall rate. When out_o stalls the queue fills and then in_i.ready drops;
// nothing is lost. Reset empties the queue, clears the decoder state and sets
// emit_units.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  u8u16_in_if.sink             in_i,
  u8u16_cfg_if.sink            cfg_i,
  u8u16_out_if.source          out_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned OccW  = $clog2(Depth + 1);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  // input register
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       eos_q;

  // decoder state
  logic [1:0]                    phase_q, phase_d;
  logic [u8u16_pkg::AccW-1:0]    acc_q, acc_d;
  logic [COUNT_WIDTH-1:0]        cnt_q, cnt_d;
  logic                          disc_q, disc_d;
  logic                          emit_q;

  // result queue
  u8u16_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OccW-1:0] occ_q;

  // decode results
  logic                          close;
  u8u16_pkg::item_kind_e         close_kind;
  logic [1:0]                    nu;
  logic [1:0]                    ne;
  logic [1:0]                    n_push;
  logic [u8u16_pkg::CodeUnitW-1:0] ua, ub;
  logic [COUNT_WIDTH-1:0]        c1, c2, cnt_fin;
  u8u16_pkg::result_t            wr [3];
  logic                          pop;
  logic                          proceed;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == CountMax) ? c : c + COUNT_WIDTH'(1);
  endfunction

  assign c1 = sat_inc(cnt_q);
  assign c2 = sat_inc(c1);

  always_comb begin
    logic [u8u16_pkg::AccW-1:0] acc_n;
    logic [1:0]                 phase_n;
    logic [u8u16_pkg::AccW-1:0] v;
    close      = 1'b0;
    close_kind = u8u16_pkg::KIND_DONE;
    nu         = 2'd0;
    ua         = '0;
    ub         = '0;
    phase_d    = phase_q;
    acc_d      = acc_q;
    disc_d     = disc_q;
    acc_n      = {acc_q[u8u16_pkg::AccW-7:0], byte_q[5:0]};
    phase_n    = phase_q - 2'd1;
    v          = acc_n - u8u16_pkg::SuppBase;
    if (disc_q) begin
      if (eos_q) begin
        disc_d = 1'b0;
      end
    end else if (phase_q == u8u16_pkg::PhaseLead) begin
      if (byte_q == 8'h00) begin
        close = 1'b1;
      end else if (byte_q < u8u16_pkg::AsciiLimit) begin
        nu    = 2'd1;
        ua    = u8u16_pkg::CodeUnitW'(byte_q);
        close = eos_q;
      end else if (byte_q < u8u16_pkg::Lead2Min || byte_q >= u8u16_pkg::LeadLimit) begin
        close      = 1'b1;
        close_kind = u8u16_pkg::KIND_ERROR;
      end else begin
        if (byte_q < u8u16_pkg::Lead3Min) begin
          phase_d = u8u16_pkg::PhaseOne;
          acc_d   = u8u16_pkg::AccW'(byte_q[4:0]);
        end else if (byte_q < u8u16_pkg::Lead4Min) begin
          phase_d = u8u16_pkg::PhaseTwo;
          acc_d   = u8u16_pkg::AccW'(byte_q[3:0]);
        end else begin
          phase_d = u8u16_pkg::PhaseThree;
          acc_d   = u8u16_pkg::AccW'(byte_q[2:0]);
        end
        close      = eos_q;
        close_kind = u8u16_pkg::KIND_ERROR;
      end
    end else if ((byte_q & u8u16_pkg::ContMask) != u8u16_pkg::ContTag) begin
      close      = 1'b1;
      close_kind = u8u16_pkg::KIND_ERROR;
    end else if (phase_n != u8u16_pkg::PhaseLead) begin
      phase_d    = phase_n;
      acc_d      = acc_n;
      close      = eos_q;
      close_kind = u8u16_pkg::KIND_ERROR;
    end else begin
      phase_d = u8u16_pkg::PhaseLead;
      acc_d   = '0;
      if ((acc_n >= u8u16_pkg::SurrMin && acc_n <= u8u16_pkg::SurrMax) ||
          acc_n > u8u16_pkg::CpMax) begin
        close      = 1'b1;
        close_kind = u8u16_pkg::KIND_ERROR;
      end else if (acc_n >= u8u16_pkg::SuppBase) begin
        // surrogate pair
        nu    = 2'd2;
        ua    = u8u16_pkg::HiSurrBase + u8u16_pkg::CodeUnitW'(v[19:10]);
        ub    = u8u16_pkg::LoSurrBase + u8u16_pkg::CodeUnitW'(v[9:0]);
        close = eos_q;
      end else begin
        nu    = 2'd1;
        ua    = acc_n[u8u16_pkg::CodeUnitW-1:0];
        close = eos_q;
      end
    end
    if (close) begin
      phase_d = u8u16_pkg::PhaseLead;
      acc_d   = '0;
      disc_d  = !eos_q;
    end
  end

  always_comb begin
    unique case (nu)
      2'd0:    cnt_fin = cnt_q;
      2'd1:    cnt_fin = c1;
      default: cnt_fin = c2;
    endcase
    if (disc_q) begin
      cnt_d = eos_q ? '0 : cnt_q;
    end else if (close && eos_q) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_fin;
    end
  end

  assign ne     = emit_q ? nu : 2'd0;
  assign n_push = ne + {1'b0, close};

  always_comb begin
    u8u16_pkg::result_t u0, u1, st;
    u0.item_kind      = u8u16_pkg::KIND_UNIT;
    u0.code_unit      = ua;
    u0.unit_count     = u8u16_pkg::UnitCountW'(c1);
    u0.last_of_string = 1'b0;
    u1.item_kind      = u8u16_pkg::KIND_UNIT;
    u1.code_unit      = ub;
    u1.unit_count     = u8u16_pkg::UnitCountW'(c2);
    u1.last_of_string = 1'b0;
    st.item_kind      = close_kind;
    st.code_unit      = '0;
    st.unit_count     = u8u16_pkg::UnitCountW'(cnt_fin);
    st.last_of_string = 1'b1;
    wr[0] = (ne >= 2'd1) ? u0 : st;
    wr[1] = (ne >= 2'd2) ? u1 : st;
    wr[2] = st;
  end

  assign pop     = out_o.valid && out_o.ready;
  // room left after this cycle's pop must hold every item of this byte
  assign proceed = in_vld_q &&
                   ({1'b0, n_push} + occ_q <= OccW'(Depth) + OccW'(pop));

  assign in_i.ready  = !in_vld_q || proceed;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (proceed) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.byte_in;
      eos_q  <= in_i.end_of_string;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= u8u16_pkg::PhaseLead;
      acc_q   <= '0;
      cnt_q   <= '0;
      disc_q  <= 1'b0;
    end else if (proceed) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      disc_q  <= disc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      emit_q <= cfg_i.emit_units;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(n_push)) begin
          mem_q[wr_ptr_q + PtrW'(k)] <= wr[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
    end else begin
      if (proceed) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      occ_q <= occ_q + (proceed ? OccW'(n_push) : OccW'(0)) - OccW'(pop);
    end
  end

  assign out_o.valid          = (occ_q != '0);
  assign out_o.item_kind      = mem_q[rd_ptr_q].item_kind;
  assign out_o.code_unit      = mem_q[rd_ptr_q].code_unit;
  assign out_o.unit_count     = mem_q[rd_ptr_q].unit_count;
  assign out_o.last_of_string = mem_q[rd_ptr_q].last_of_string;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(Depth))
    else $error("result queue overflow");

  a_disc_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && disc_q) |-> (n_push == 2'd0))
    else $error("items produced while discarding");

  a_disc_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (phase_q == u8u16_pkg::PhaseLead))
    else $error("discarding inside a sequence");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && eos_q) |=> (cnt_q == '0 && phase_q == u8u16_pkg::PhaseLead && !disc_q) ||
                           $past(phase_d != u8u16_pkg::PhaseLead))
    else $error("end of string did not restart the decoder");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == PtrW'(occ_q))
    else $error("queue pointers disagree with occupancy");
`endif

endmodule
